@@ design/fcfl_pkg.sv @@
// Shared types and constants of the chunk free-list allocator.
package fcfl_pkg;

   // request codes
   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_FREE    = 2'd1;
   localparam logic [1:0] REQ_REBUILD = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_CHUNK_COUNT  = 2'd0;
   localparam logic [1:0] CSR_CHUNK_SIZE   = 2'd1;
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd2;

   localparam logic [8:0]  CHUNK_COUNT_RESET  = 9'd256;
   localparam logic [15:0] CHUNK_SIZE_RESET   = 16'd64;
   localparam logic [31:0] BASE_ADDRESS_RESET = 32'd0;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_ALLOC,
      ST_REBUILD
   } fcfl_state_type;

   // control from the sequencer to the link store
   typedef struct packed {
      logic sweep_start;
      logic wr_en;
      logic rd_en;
   } fcfl_mem_ctl_type;

endpackage

@@ design/fixed_chunk_free_list_allocator_core.sv @@
// Top level of the fixed-size chunk pool allocator (LIFO free list).
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_ready  req_type, req_chunk_index
//   rsp      out        rsp_valid/rsp_ready  status, index, address, free count
//   csr      in         csr_write            csr_index, csr_wdata
//
// Allocate passes through ST_ALLOC: the link of the head comes from the registered link RAM read.
// Free and empty/out-of-range/unused requests are answered straight from ST_IDLE.
// Rebuild rewrites every RAM entry, one a cycle, and answers when the sweep ends.
// After reset the same sweep runs and req_ready stays low until it ends.
// A new request is taken once the response register is empty or being drained.
module fixed_chunk_free_list_allocator_core import fcfl_pkg::*; #(
   parameter int MAX_CHUNKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_chunk_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_granted_index,
   output logic [31:0] rsp_granted_address,
   output logic [8:0]  rsp_free_count,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W   = $clog2(MAX_CHUNKS);
   localparam int LINK_W  = IDX_W + 1;
   localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
   localparam int CMP_W   = (CNT_W > 9) ? CNT_W : 9;
   localparam int WIDE_W  = (IDX_W > 8) ? IDX_W : 8;
   localparam int PROD_W  = IDX_W + 16;
   localparam int RESET_N = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_CHUNKS);

   // configuration
   logic [8:0]  chunk_count_ff;
   logic [15:0] chunk_size_ff;
   logic [31:0] base_address_ff;

   // sequencer and free-list state
   fcfl_state_type    state_ff, state_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  free_total_ff, free_total_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_index_ff, rsp_index_in;
   logic [31:0]       rsp_address_ff, rsp_address_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   fcfl_mem_ctl_type  mem_ctl;
   logic [LINK_W-1:0] rd_data;
   logic              sweep_busy;

   logic [CMP_W-1:0]  cc_wide;
   logic [CNT_W-1:0]  active_n;
   logic              req_fire;
   logic              head_null;
   logic [WIDE_W-1:0] free_idx_wide;
   logic [WIDE_W-1:0] head_idx_wide;
   logic              free_in_range;
   logic [PROD_W-1:0] addr_prod;
   logic [31:0]       grant_address;
   logic [CMP_W-1:0]  count_wide;

   // effective chunk count: zero acts as one, clipped to the pool size
   assign cc_wide = CMP_W'(chunk_count_ff);
   always_comb begin
      if (cc_wide == '0) begin
         active_n = CNT_W'(1);
      end else if (cc_wide > CMP_W'(MAX_CHUNKS)) begin
         active_n = CNT_W'(MAX_CHUNKS);
      end else begin
         active_n = CNT_W'(cc_wide);
      end
   end

   assign req_ready     = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire      = req_valid && req_ready;
   assign head_null     = (head_ff == NULL_LINK);
   assign free_idx_wide = WIDE_W'(req_chunk_index);
   assign head_idx_wide = WIDE_W'(head_ff[IDX_W-1:0]);
   assign free_in_range = CMP_W'(req_chunk_index) < CMP_W'(active_n);

   assign addr_prod     = PROD_W'(head_ff[IDX_W-1:0]) * PROD_W'(chunk_size_ff);
   assign grant_address = base_address_ff + 32'(addr_prod);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (!sweep_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_ALLOC && !head_null) begin
                  state_in = ST_ALLOC;
               end else if (req_type == REQ_REBUILD) begin
                  state_in = ST_REBUILD;
               end
            end
         end
         ST_ALLOC: begin
            state_in = ST_IDLE;
         end
         ST_REBUILD: begin
            if (!sweep_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      mem_ctl        = '0;
      head_in        = head_ff;
      free_total_in  = free_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_address_in = rsp_address_ff;
      rsp_count_in   = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_status_in  = STAT_OK;
               rsp_index_in   = '0;
               rsp_address_in = '0;
               rsp_count_in   = free_total_ff;
               case (req_type)
                  REQ_ALLOC: begin
                     if (head_null) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                     end
                  end
                  REQ_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (free_in_range) begin
                        mem_ctl.wr_en = 1'b1;
                        head_in       = LINK_W'(free_idx_wide[IDX_W-1:0]);
                        if (free_total_ff < active_n) begin
                           free_total_in = free_total_ff + CNT_W'(1);
                        end
                        rsp_count_in = free_total_in;
                     end else begin
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  REQ_REBUILD: begin
                     mem_ctl.sweep_start = 1'b1;
                     head_in             = '0;
                     free_total_in       = active_n;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            head_in = rd_data;
            if (free_total_ff != '0) begin
               free_total_in = free_total_ff - CNT_W'(1);
            end
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STAT_OK;
            rsp_index_in   = head_idx_wide[7:0];
            rsp_address_in = grant_address;
            rsp_count_in   = free_total_in;
         end
         ST_REBUILD: begin
            if (!sweep_busy) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_OK;
               rsp_index_in   = '0;
               rsp_address_in = '0;
               rsp_count_in   = free_total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         head_ff         <= '0;
         free_total_ff   <= CNT_W'(RESET_N);
         rsp_valid_ff    <= 1'b0;
         chunk_count_ff  <= CHUNK_COUNT_RESET;
         chunk_size_ff   <= CHUNK_SIZE_RESET;
         base_address_ff <= BASE_ADDRESS_RESET;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_CHUNK_COUNT:  chunk_count_ff  <= csr_wdata[8:0];
               CSR_CHUNK_SIZE:   chunk_size_ff   <= csr_wdata[15:0];
               CSR_BASE_ADDRESS: base_address_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_address_ff <= rsp_address_in;
      rsp_count_ff   <= rsp_count_in;
   end

   fcfl_link_store #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_link_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mem_ctl),
      .sweep_count (active_n),
      .wr_addr     (free_idx_wide[IDX_W-1:0]),
      .wr_data     (head_ff),
      .rd_addr     (head_ff[IDX_W-1:0]),
      .rd_data     (rd_data),
      .sweep_busy  (sweep_busy)
   );

   assign count_wide          = CMP_W'(rsp_count_ff);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_index   = rsp_index_ff;
   assign rsp_granted_address = rsp_address_ff;
   assign rsp_free_count      = count_wide[8:0];

endmodule

@@ design/fcfl_link_store.sv @@
// Link store memory with its relinking sweep.
module fcfl_link_store import fcfl_pkg::*; #(
   parameter int MAX_CHUNKS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcfl_mem_ctl_type                      ctl,
   input  logic [$clog2(MAX_CHUNKS+1)-1:0]       sweep_count,
   input  logic [$clog2(MAX_CHUNKS)-1:0]         wr_addr,
   input  logic [$clog2(MAX_CHUNKS):0]           wr_data,
   input  logic [$clog2(MAX_CHUNKS)-1:0]         rd_addr,
   output logic [$clog2(MAX_CHUNKS):0]           rd_data,
   output logic                                  sweep_busy
);

   localparam int IDX_W   = $clog2(MAX_CHUNKS);
   localparam int LINK_W  = IDX_W + 1;
   localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
   localparam int RESET_N = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_CHUNKS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_CHUNKS - 1);

   logic [LINK_W-1:0] link_mem [MAX_CHUNKS];
   logic [LINK_W-1:0] rd_data_ff;

   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  sweep_n_ff, sweep_n_in;

   logic [LINK_W-1:0] sweep_next;
   logic [LINK_W-1:0] sweep_wdata;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [LINK_W-1:0] mem_wdata;

   // entry i links to i+1 while inside the pool, else null
   assign sweep_next  = LINK_W'(idx_ff) + LINK_W'(1);
   assign sweep_wdata = (sweep_next < LINK_W'(sweep_n_ff)) ? sweep_next : NULL_LINK;

   assign mem_we    = busy_ff | ctl.wr_en;
   assign mem_waddr = busy_ff ? idx_ff : wr_addr;
   assign mem_wdata = busy_ff ? sweep_wdata : wr_data;

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      sweep_n_in = sweep_n_ff;
      if (ctl.sweep_start) begin
         busy_in    = 1'b1;
         idx_in     = '0;
         sweep_n_in = sweep_count;
      end else if (busy_ff) begin
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         idx_ff     <= '0;
         sweep_n_ff <= CNT_W'(RESET_N);
      end else begin
         busy_ff    <= busy_in;
         idx_ff     <= idx_in;
         sweep_n_ff <= sweep_n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign sweep_busy = busy_ff;

endmodule

@@ bench/fixed_chunk_free_list_allocator_core_tb.sv @@
// Self-checking testbench for the fixed-size chunk pool allocator core.
`timescale 1ns / 1ps

module fixed_chunk_free_list_allocator_core_tb;
   import fcfl_pkg::*;

   localparam int         POOL_SLOTS   = 256;
   localparam logic [8:0] NULL_LINK    = 9'd256;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         END_SETTLE   = 300;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         PHASES       = 8;
   localparam int         PHASE_WORDS  = 72;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  index;
      logic [31:0] address;
      logic [8:0]  free_count;
   } grant_type;

   typedef struct packed {
      bit          is_csr;
      logic [1:0]  reg_sel;
      logic [31:0] reg_val;
      logic [1:0]  kind;
      logic [7:0]  idx;
      bit          typed;
      grant_type   want;
   } drill_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [7:0]  req_chunk_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_granted_index;
   logic [31:0] rsp_granted_address;
   logic [8:0]  rsp_free_count;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   fixed_chunk_free_list_allocator_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_chunk_index     (req_chunk_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_count      (rsp_free_count),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // free-list shadow
   logic [8:0]  chain_link [0:POOL_SLOTS-1];
   logic [8:0]  chain_head;
   logic [8:0]  chain_free;
   logic [8:0]  pool_count_reg;
   logic [15:0] pool_size_reg;
   logic [31:0] pool_base_reg;

   grant_type     pending_grants [$];
   logic [7:0]    held_chunks [$];
   drill_row_type drill_plan [$];

   int  mismatches = 0;
   int  rsp_seen = 0;
   int  cycle_count = 0;
   int  words_sent = 0;
   int  grants_ok = 0;
   int  grants_empty = 0;
   int  range_errs = 0;
   int  rebuilds = 0;
   int  csr_writes = 0;
   bit  sender_calm = 0;
   bit  long_hold_request = 0;

   always #10 clock = ~clock;

   function automatic logic [8:0] live_count();
      if (pool_count_reg == 9'd0) return 9'd1;
      if (pool_count_reg > 9'(POOL_SLOTS)) return 9'(POOL_SLOTS);
      return pool_count_reg;
   endfunction

   function automatic void relink_pool();
      logic [8:0] n;
      n = live_count();
      for (int i = 0; i < POOL_SLOTS; i++)
         chain_link[i] = (i + 1 < int'(n)) ? 9'(i + 1) : NULL_LINK;
      chain_head = 9'd0;
      chain_free = n;
   endfunction

   // works out the response word for one request and advances the shadow
   function automatic grant_type predict_grant(input logic [1:0] kind,
                                               input logic [7:0] ix);
      grant_type  g;
      logic [8:0] n;
      g = '0;
      n = live_count();
      case (kind)
         REQ_ALLOC: begin
            if (chain_head == NULL_LINK) begin
               g.status = STAT_EMPTY;
            end else begin
               g.index = chain_head[7:0];
               chain_head = chain_link[g.index];
               if (chain_free != 9'd0) chain_free = chain_free - 9'd1;
               g.address = pool_base_reg + 32'(g.index) * 32'(pool_size_reg);
            end
         end
         REQ_FREE: begin
            if ({1'b0, ix} >= n) begin
               g.status = STAT_RANGE;
            end else begin
               chain_link[ix] = chain_head;
               chain_head = {1'b0, ix};
               if (chain_free < n) chain_free = chain_free + 9'd1;
            end
         end
         REQ_REBUILD: relink_pool();
         default: ;
      endcase
      g.free_count = chain_free;
      return g;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic drill_row_type row_req(input logic [1:0] kind, input logic [7:0] ix);
      drill_row_type row;
      row = '0;
      row.kind = kind;
      row.idx = ix;
      return row;
   endfunction

   function automatic drill_row_type row_chk(input logic [1:0] kind, input logic [7:0] ix,
                                             input logic [1:0] st, input logic [7:0] gi,
                                             input logic [31:0] ga, input logic [8:0] fc);
      drill_row_type row;
      row = row_req(kind, ix);
      row.typed = 1'b1;
      row.want = '{status: st, index: gi, address: ga, free_count: fc};
      return row;
   endfunction

   function automatic drill_row_type row_csr(input logic [1:0] sel, input logic [31:0] val);
      drill_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.reg_sel = sel;
      row.reg_val = val;
      return row;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [1:0] kind, input logic [7:0] ix,
                            input bit typed, input grant_type typed_want);
      grant_type g;
      int        gap;
      if (words_sent % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      gap = (!sender_calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      g = predict_grant(kind, ix);
      pending_grants.push_back(typed ? typed_want : g);
      words_sent++;
      if (kind == REQ_REBUILD) begin
         rebuilds++;
         held_chunks.delete();
      end
      if (g.status == STAT_EMPTY) grants_empty++;
      if (g.status == STAT_RANGE) range_errs++;
      if (kind == REQ_ALLOC && g.status == STAT_OK) begin
         grants_ok++;
         held_chunks.push_back(g.index);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_chunk_index <= ix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      case (sel)
         CSR_CHUNK_COUNT:  pool_count_reg = val[8:0];
         CSR_CHUNK_SIZE:   pool_size_reg = val[15:0];
         CSR_BASE_ADDRESS: pool_base_reg = val;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_grants.size());
         $display("fixed_chunk_free_list_allocator_core_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin : check_rsp
      grant_type got;
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_granted_index, rsp_granted_address, rsp_free_count};
         rsp_seen++;
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp %0d: word with nothing expected (status %0d index %0d %s",
                        rsp_seen, got.status, got.index, "...");
         end else begin
            want = pending_grants.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"rsp %0d: status %0d/%0d index %0d/%0d addr %h/%h",
                            " free %0d/%0d (exp/got)"},
                           rsp_seen, want.status, got.status, want.index, got.index,
                           want.address, got.address, want.free_count, got.free_count);
            end
         end
      end
   end

   // response side: random back-pressure, calm stretches and one long hold-off
   initial begin : rsp_side
      int pause_left;
      int mode_left;
      bit calm;
      pause_left = 0;
      mode_left = 0;
      calm = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            pause_left = HOLD_CYCLES;
         end
         if (pause_left > 0) begin
            rsp_ready <= 1'b0;
            pause_left--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            pause_left = gap_len() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stim
      drill_row_type row;
      logic [8:0]    cnt;
      logic [15:0]   sz;
      logic [31:0]   bs;
      logic [7:0]    ix;
      logic [1:0]    kind;
      int            r;
      int            pos;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_ALLOC;
      req_chunk_index = 8'd0;
      csr_write = 1'b0;
      csr_index = CSR_CHUNK_COUNT;
      csr_wdata = 32'd0;

      pool_count_reg = CHUNK_COUNT_RESET;
      pool_size_reg = CHUNK_SIZE_RESET;
      pool_base_reg = BASE_ADDRESS_RESET;
      relink_pool();

      // reset state, then double free, unused code, shrunk pool, count floor at zero,
      // empty pool, address wrap, out-of-range counts and saturation at the top
      drill_plan.push_back(row_chk(REQ_ALLOC, 8'd0, STAT_OK, 8'd0, 32'd0, 9'd255));
      drill_plan.push_back(row_chk(REQ_ALLOC, 8'd0, STAT_OK, 8'd1, 32'd64, 9'd254));
      drill_plan.push_back(row_req(REQ_FREE, 8'd255));
      drill_plan.push_back(row_req(REQ_FREE, 8'd255));
      drill_plan.push_back(row_req(2'd3, 8'd255));
      drill_plan.push_back(row_chk(REQ_REBUILD, 8'd0, STAT_OK, 8'd0, 32'd0, 9'd256));
      drill_plan.push_back(row_csr(CSR_CHUNK_COUNT, 32'd2));
      drill_plan.push_back(row_chk(REQ_FREE, 8'd2, STAT_RANGE, 8'd0, 32'd0, 9'd256));
      drill_plan.push_back(row_chk(REQ_REBUILD, 8'd0, STAT_OK, 8'd0, 32'd0, 9'd2));
      drill_plan.push_back(row_req(REQ_FREE, 8'd0));
      drill_plan.push_back(row_req(REQ_ALLOC, 8'd0));
      drill_plan.push_back(row_req(REQ_ALLOC, 8'd0));
      drill_plan.push_back(row_req(REQ_ALLOC, 8'd0));
      drill_plan.push_back(row_chk(REQ_REBUILD, 8'd0, STAT_OK, 8'd0, 32'd0, 9'd2));
      drill_plan.push_back(row_chk(REQ_ALLOC, 8'd0, STAT_OK, 8'd0, 32'd0, 9'd1));
      drill_plan.push_back(row_chk(REQ_ALLOC, 8'd0, STAT_OK, 8'd1, 32'd64, 9'd0));
      drill_plan.push_back(row_chk(REQ_ALLOC, 8'd0, STAT_EMPTY, 8'd0, 32'd0, 9'd0));
      drill_plan.push_back(row_csr(CSR_CHUNK_SIZE, 32'd65535));
      drill_plan.push_back(row_csr(CSR_BASE_ADDRESS, 32'hFFFF_FFF0));
      drill_plan.push_back(row_req(REQ_FREE, 8'd1));
      drill_plan.push_back(row_req(REQ_ALLOC, 8'd0));
      drill_plan.push_back(row_csr(CSR_CHUNK_COUNT, 32'd0));
      drill_plan.push_back(row_chk(REQ_REBUILD, 8'd0, STAT_OK, 8'd0, 32'd0, 9'd1));
      drill_plan.push_back(row_chk(REQ_FREE, 8'd1, STAT_RANGE, 8'd0, 32'd0, 9'd1));
      drill_plan.push_back(row_chk(REQ_ALLOC, 8'd0, STAT_OK, 8'd0, 32'hFFFF_FFF0, 9'd0));
      drill_plan.push_back(row_chk(REQ_ALLOC, 8'd0, STAT_EMPTY, 8'd0, 32'd0, 9'd0));
      drill_plan.push_back(row_csr(CSR_CHUNK_COUNT, 32'd511));
      drill_plan.push_back(row_chk(REQ_REBUILD, 8'd0, STAT_OK, 8'd0, 32'd0, 9'd256));
      drill_plan.push_back(row_req(REQ_FREE, 8'd255));
      drill_plan.push_back(row_req(REQ_ALLOC, 8'd0));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (drill_plan[i]) begin
         row = drill_plan[i];
         if (row.is_csr) begin
            drain();
            write_reg(row.reg_sel, row.reg_val);
         end else begin
            send_word(row.kind, row.idx, row.typed, row.want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         cnt = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(2, 16));
         sz = 16'($urandom_range(8, 65535));
         bs = $urandom;
         case (phase)
            0: cnt = 9'd1;
            1: cnt = 9'd256;
            2: begin cnt = 9'd0; sz = 16'd8; end
            3: begin cnt = 9'd511; sz = 16'd65535; end
            4: bs = 32'hFFFF_FFFF;
            5: bs = 32'd0;
            default: ;
         endcase
         drain();
         write_reg(CSR_CHUNK_COUNT, 32'(cnt));
         write_reg(CSR_CHUNK_SIZE, 32'(sz));
         write_reg(CSR_BASE_ADDRESS, bs);
         // full pool with the response side held off: input must back up
         if (phase == 1) long_hold_request = 1'b1;
         if (phase < 2 || $urandom_range(0, 3) != 0)
            send_word(REQ_REBUILD, 8'($urandom_range(0, 255)), 1'b0, '0);

         for (int k = 0; k < PHASE_WORDS; k++) begin
            r = $urandom_range(0, 99);
            ix = 8'($urandom_range(0, 255));
            if (r < 45) begin
               kind = REQ_ALLOC;
            end else if (r < 85) begin
               kind = REQ_FREE;
               if (held_chunks.size() != 0 && $urandom_range(0, 3) != 0) begin
                  pos = $urandom_range(0, held_chunks.size() - 1);
                  ix = held_chunks[pos];
                  held_chunks.delete(pos);
               end else if ($urandom_range(0, 1) == 0) begin
                  ix = 8'($urandom_range(0, int'(live_count())));
               end
            end else if (r < 88) begin
               kind = REQ_REBUILD;
            end else if (r < 93) begin
               kind = 2'd3;
            end else begin
               kind = REQ_FREE;
            end
            send_word(kind, ix, 1'b0, '0);
         end
      end

      drain();
      repeat (END_SETTLE) @(negedge clock);

      $display("%0d request words over %0d register writes: %0d grants, %0d empty,",
               words_sent, csr_writes, grants_ok, grants_empty);
      $display("%0d range errors, %0d rebuilds, %0d response words checked,",
               range_errs, rebuilds, rsp_seen);
      $display("one %0d-cycle response hold-off", HOLD_CYCLES);
      if (mismatches == 0 && pending_grants.size() == 0) begin
         $display("fixed_chunk_free_list_allocator_core_tb: done, clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending_grants.size());
         $display("fixed_chunk_free_list_allocator_core_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/fcfl_pkg.sv
design/fcfl_link_store.sv
design/fixed_chunk_free_list_allocator_core.sv
bench/fixed_chunk_free_list_allocator_core_tb.sv
